/* src/wtab_pkg.sv */
package wtab_pkg;

   // register map of the configuration port
   typedef enum logic [2:0] {
      CSR_FULL_SCALE    = 3'd0,
      CSR_BCD_MODE      = 3'd1,
      CSR_BCD_SIGNED    = 3'd2,
      CSR_INVERT_OUTPUT = 3'd3,
      CSR_ERROR_LOW     = 3'd4,
      CSR_DIGIT_START   = 3'd5
   } csr_index_type;

   localparam int unsigned WEIGHT_W = 20;
   localparam int unsigned CODE_W   = 16;
   localparam int unsigned NUM_W    = 32;
   localparam int unsigned BCD_W    = 24;
   localparam int unsigned DIGITS   = 6;

   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX      = 20'd999999;
   localparam logic [WEIGHT_W-1:0] FULL_SCALE_RST  = 20'd999999;
   localparam logic [1:0]          DIGIT_START_RST = 2'd1;
   localparam logic [11:0]         ANALOG_SPAN     = 12'd4095;
   localparam logic [CODE_W-1:0]   ANALOG_ERR_CODE = 16'h0FFF;
   localparam logic [CODE_W-1:0]   BCD_CLAMP       = 16'h7999;
   localparam logic [CODE_W-1:0]   BCD_SIGN        = 16'h8000;

   localparam logic [1:0] FUNC_NEVER  = 2'd0;
   localparam logic [1:0] FUNC_ALWAYS = 2'd2;

   // pipeline shape: quotient bits and double-dabble shifts per stage
   localparam int unsigned NSTG          = 8;
   localparam int unsigned DIV_PER_STG   = 2;
   localparam int unsigned DD_PER_STG    = 3;
   localparam int unsigned DD_STEPS      = WEIGHT_W;

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic                err;
      logic                zero;
      logic                over;
      logic                neg;
   } front_type;

   typedef struct packed {
      logic                err;
      logic                zero;
      logic                over;
      logic                neg;
      logic                ovf;
      logic [WEIGHT_W-1:0] rem;
      logic [CODE_W-1:0]   dq;
      logic [BCD_W-1:0]    bcd;
      logic [WEIGHT_W-1:0] src;
   } mid_type;

endpackage

/* src/weight_to_analog_or_bcd_code.sv */
// Weight to output code encoder: analog DAC word or packed BCD digits.
// Input channel req_*: one word per accepted cycle (req_valid high, req_stall
// low) carrying function code, weight magnitude and zero/overload/negative
// flags. Result channel rsp_*: one 16-bit code per input word, in order;
// the receiver holds rsp_stall high to keep the word on the port.
// Config channel csr_*: register index and data, always ready. Write it only
// while the pipeline is empty.
// Throughput is one word per cycle while the output is not stalled. Words
// pass through an input stage, a multiply stage, the restoring divider for
// weight*4095/full_scale (two quotient bits per stage over 8 stages, with
// the binary to BCD shifts running alongside in the same stages) and the
// output register.
// Each stage advances whenever the stage after it is empty or moving, so
// bubbles close up while the output stalls; only a full pipeline raises
// req_stall. Reset empties every stage and loads the register defaults:
// full scale 999999, analog mode, no inversion, error code high, first
// digit one.
module weight_to_analog_or_bcd_code
   import wtab_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_func,
   input  logic [WEIGHT_W-1:0] req_weight,
   input  logic                req_zero_flag,
   input  logic                req_overload_flag,
   input  logic                req_negative_flag,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CODE_W-1:0]   rsp_code,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [WEIGHT_W-1:0] csr_data
);

   logic [WEIGHT_W-1:0] full_scale_ff;
   logic                bcd_mode_ff;
   logic                bcd_signed_ff;
   logic                invert_output_ff;
   logic                error_low_ff;
   logic [1:0]          digit_start_ff;
   logic [WEIGHT_W-1:0] fs_eff;

   front_type           s0_ff;
   front_type           s0_in;
   logic                s0_v_ff;
   logic                s0_rdy;

   mid_type             mid_ff   [0:NSTG];
   mid_type             mid_in   [0:NSTG];
   logic [NSTG:0]       mid_v_ff;
   logic [NSTG:0]       mid_rdy;

   logic                rsp_valid_ff;
   logic [CODE_W-1:0]   code_ff;
   logic [CODE_W-1:0]   code_in;
   logic                out_rdy;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff    <= FULL_SCALE_RST;
         bcd_mode_ff      <= 1'b0;
         bcd_signed_ff    <= 1'b0;
         invert_output_ff <= 1'b0;
         error_low_ff     <= 1'b0;
         digit_start_ff   <= DIGIT_START_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FULL_SCALE:    full_scale_ff    <= csr_data;
            CSR_BCD_MODE:      bcd_mode_ff      <= csr_data[0];
            CSR_BCD_SIGNED:    bcd_signed_ff    <= csr_data[0];
            CSR_INVERT_OUTPUT: invert_output_ff <= csr_data[0];
            CSR_ERROR_LOW:     error_low_ff     <= csr_data[0];
            CSR_DIGIT_START:   digit_start_ff   <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   assign fs_eff = (full_scale_ff == '0) ? WEIGHT_W'(1) : full_scale_ff;

   // flow control: a stage loads when empty or when its successor loads
   assign out_rdy = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      mid_rdy[NSTG] = !mid_v_ff[NSTG] || out_rdy;
      for (int k = NSTG - 1; k >= 0; k--) begin
         mid_rdy[k] = !mid_v_ff[k] || mid_rdy[k+1];
      end
   end

   assign s0_rdy    = !s0_v_ff || mid_rdy[0];
   assign req_stall = !s0_rdy;

   // input stage: saturate weight, resolve error condition
   always_comb begin
      s0_in.weight = (req_weight > WEIGHT_MAX) ? WEIGHT_MAX : req_weight;
      s0_in.err    = (req_func != FUNC_NEVER) &&
                     ((req_func == FUNC_ALWAYS) || req_overload_flag);
      s0_in.zero   = req_zero_flag;
      s0_in.over   = req_overload_flag;
      s0_in.neg    = req_negative_flag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (s0_rdy) begin
         s0_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && s0_rdy) begin
         s0_ff <= s0_in;
      end
   end

   // multiply stage: numerator and overflow check against full scale
   always_comb begin
      logic [NUM_W-1:0] num;
      logic [WEIGHT_W-1:0] hi;
      num = {12'b0, s0_ff.weight} * {20'b0, ANALOG_SPAN};
      hi  = {4'b0, num[NUM_W-1:CODE_W]};
      mid_in[0].err  = s0_ff.err;
      mid_in[0].zero = s0_ff.zero;
      mid_in[0].over = s0_ff.over;
      mid_in[0].neg  = s0_ff.neg;
      // quotient above 16 bits saturates
      mid_in[0].ovf  = (hi >= fs_eff);
      mid_in[0].rem  = (hi >= fs_eff) ? '0 : hi;
      mid_in[0].dq   = num[CODE_W-1:0];
      mid_in[0].bcd  = '0;
      mid_in[0].src  = s0_ff.weight;
   end

   // divider / double-dabble stages
   for (genvar g = 0; g < NSTG; g++) begin : g_stage
      always_comb begin
         mid_type s;
         logic [WEIGHT_W:0] r21;
         logic qb;
         s = mid_ff[g];
         for (int j = 0; j < DIV_PER_STG; j++) begin
            r21 = {s.rem, s.dq[CODE_W-1]};
            qb  = 1'b0;
            if (r21 >= {1'b0, fs_eff}) begin
               r21 = r21 - {1'b0, fs_eff};
               qb  = 1'b1;
            end
            s.rem = r21[WEIGHT_W-1:0];
            s.dq  = {s.dq[CODE_W-2:0], qb};
         end
         for (int j = 0; j < DD_PER_STG; j++) begin
            if (g * DD_PER_STG + j < DD_STEPS) begin
               for (int d = 0; d < DIGITS; d++) begin
                  if (s.bcd[4*d +: 4] >= 4'd5) begin
                     s.bcd[4*d +: 4] = s.bcd[4*d +: 4] + 4'd3;
                  end
               end
               {s.bcd, s.src} = {s.bcd[BCD_W-2:0], s.src, 1'b0};
            end
         end
         mid_in[g+1] = s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_v_ff <= '0;
      end else begin
         if (mid_rdy[0]) begin
            mid_v_ff[0] <= s0_v_ff;
         end
         for (int k = 1; k <= NSTG; k++) begin
            if (mid_rdy[k]) begin
               mid_v_ff[k] <= mid_v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mid_rdy[0] && s0_v_ff) begin
         mid_ff[0] <= mid_in[0];
      end
      for (int k = 1; k <= NSTG; k++) begin
         if (mid_rdy[k] && mid_v_ff[k-1]) begin
            mid_ff[k] <= mid_in[k];
         end
      end
   end

   // output formatting
   always_comb begin
      logic [CODE_W-1:0] packed_bcd;
      logic [CODE_W-1:0] y;
      case (digit_start_ff)
         2'd2:    packed_bcd = mid_ff[NSTG].bcd[19:4];
         2'd3:    packed_bcd = mid_ff[NSTG].bcd[15:0];
         default: packed_bcd = mid_ff[NSTG].bcd[23:8];
      endcase
      if (!bcd_mode_ff) begin
         y = mid_ff[NSTG].ovf ? '1 : mid_ff[NSTG].dq;
         if (mid_ff[NSTG].zero) begin
            y = '0;
         end
         if (invert_output_ff) begin
            y = ~y;
         end
         if (mid_ff[NSTG].err) begin
            y = error_low_ff ? '0 : ANALOG_ERR_CODE;
         end
      end else if (bcd_signed_ff) begin
         // inversion is not applied on the signed path
         y = (packed_bcd > BCD_CLAMP) ? BCD_CLAMP : packed_bcd;
         if (mid_ff[NSTG].neg) begin
            y = y | BCD_SIGN;
         end
         if (mid_ff[NSTG].err) begin
            y = error_low_ff ? '0 : '1;
         end
      end else begin
         y = packed_bcd;
         if (mid_ff[NSTG].err) begin
            y = error_low_ff ? '0 : '1;
         end
         if (invert_output_ff && !mid_ff[NSTG].over) begin
            y = ~y;
         end
      end
      code_in = y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_rdy) begin
         rsp_valid_ff <= mid_v_ff[NSTG];
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy && mid_v_ff[NSTG]) begin
         code_ff <= code_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_code  = code_ff;

   // the input stage never pushes back while it is empty
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s0_v_ff)
      else $error("input stalled with empty front stage");

   // a word blocked in the front stage stays there
   a_front_holds: assert property (@(posedge clock) disable iff (reset)
      s0_v_ff && !mid_rdy[0] |=> s0_v_ff)
      else $error("front stage word lost while blocked");

   // last stage blocked by the output keeps its word
   a_last_holds: assert property (@(posedge clock) disable iff (reset)
      mid_v_ff[NSTG] && !out_rdy |=> mid_v_ff[NSTG])
      else $error("last stage word lost while output stalled");

   // conversion finished: every nibble is a decimal digit
   a_bcd_digits: assert property (@(posedge clock) disable iff (reset)
      mid_v_ff[NSTG] |-> (mid_ff[NSTG].bcd[3:0] <= 4'd9) &&
                         (mid_ff[NSTG].bcd[7:4] <= 4'd9) &&
                         (mid_ff[NSTG].bcd[11:8] <= 4'd9) &&
                         (mid_ff[NSTG].bcd[15:12] <= 4'd9) &&
                         (mid_ff[NSTG].bcd[19:16] <= 4'd9) &&
                         (mid_ff[NSTG].bcd[23:20] <= 4'd9))
      else $error("binary to BCD produced a non-decimal digit");

endmodule

/* tb/sv/code_check_pkg.sv */
package code_check_pkg;
   import wtab_pkg::*;

   typedef struct {
      logic [CODE_W-1:0]   code;
      logic [1:0]          func;
      logic [WEIGHT_W-1:0] weight;
   } expected_word_type;

   class code_tracker_type;
      logic [WEIGHT_W-1:0] full_scale;
      logic                bcd_mode;
      logic                bcd_signed;
      logic                invert_output;
      logic                error_low;
      logic [1:0]          digit_start;
      expected_word_type   expected_codes[$];
      int                  mismatches;
      int                  checked;

      function new();
         full_scale    = FULL_SCALE_RST;
         bcd_mode      = 1'b0;
         bcd_signed    = 1'b0;
         invert_output = 1'b0;
         error_low     = 1'b0;
         digit_start   = DIGIT_START_RST;
         mismatches    = 0;
         checked       = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [WEIGHT_W-1:0] data);
         case (idx)
            CSR_FULL_SCALE:    full_scale    = data;
            CSR_BCD_MODE:      bcd_mode      = data[0];
            CSR_BCD_SIGNED:    bcd_signed    = data[0];
            CSR_INVERT_OUTPUT: invert_output = data[0];
            CSR_ERROR_LOW:     error_low     = data[0];
            CSR_DIGIT_START:   digit_start   = data[1:0];
            default: ;
         endcase
      endfunction

      function logic [CODE_W-1:0] encode_weight(logic [1:0] func, logic [WEIGHT_W-1:0] weight,
                                                logic zero, logic over, logic neg);
         logic [WEIGHT_W-1:0] w;
         logic [WEIGHT_W-1:0] fs;
         logic [63:0]         q;
         logic [CODE_W-1:0]   y;
         logic [3:0]          digs[6];
         int                  rest;
         int                  first;
         logic                failed;
         w = (weight > WEIGHT_MAX) ? WEIGHT_MAX : weight;
         failed = (func != FUNC_NEVER) && (func == FUNC_ALWAYS || over);
         if (!bcd_mode) begin
            fs = (full_scale == '0) ? WEIGHT_W'(1) : full_scale;
            q = (64'(w) * 64'(ANALOG_SPAN)) / 64'(fs);
            y = (q > 64'hFFFF) ? '1 : q[CODE_W-1:0];
            if (zero) y = '0;
            if (invert_output) y = ~y;
            // error code overrides polarity in analog mode
            if (failed) y = error_low ? '0 : ANALOG_ERR_CODE;
         end else begin
            rest = int'(w);
            for (int k = 5; k >= 0; k--) begin
               digs[k] = 4'(rest % 10);
               rest = rest / 10;
            end
            first = (digit_start == 2'd0) ? 1 : int'(digit_start);
            y = {digs[first-1], digs[first], digs[first+1], digs[first+2]};
            if (bcd_signed) begin
               if (y > BCD_CLAMP) y = BCD_CLAMP;
               if (neg) y = y | BCD_SIGN;
               if (failed) y = error_low ? '0 : '1;
               // signed path does not invert, so polarity drops out
            end else begin
               if (failed) y = error_low ? '0 : '1;
               if (invert_output && !over) y = ~y;
            end
         end
         return y;
      endfunction

      function void note_word(logic [1:0] func, logic [WEIGHT_W-1:0] weight,
                              logic zero, logic over, logic neg);
         expected_word_type e;
         e.code   = encode_weight(func, weight, zero, over, neg);
         e.func   = func;
         e.weight = weight;
         expected_codes.push_back(e);
      endfunction

      function void report_mismatch(string msg);
         mismatches++;
         $display("ERROR: %s", msg);
      endfunction

      function void check_code(logic [CODE_W-1:0] code);
         expected_word_type e;
         checked++;
         if (expected_codes.size() == 0) begin
            report_mismatch($sformatf("code %h arrived with nothing pending", code));
         end else begin
            e = expected_codes.pop_front();
            if (code !== e.code)
               report_mismatch($sformatf("func %0d weight %0d: code %h, want %h",
                                         e.func, e.weight, code, e.code));
         end
      endfunction

      function int pending();
         return expected_codes.size();
      endfunction

      function void finish_check();
         if (expected_codes.size() != 0)
            report_mismatch($sformatf("%0d codes never arrived", expected_codes.size()));
      endfunction
   endclass

endpackage

/* tb/sv/testbench.sv */
module testbench;
   import wtab_pkg::*;
   import code_check_pkg::*;

   localparam logic [1:0] FUNC_ON_OVERLOAD = 2'd1;
   localparam logic [1:0] FUNC_SPARE       = 2'd3;
   localparam logic [2:0] CSR_UNMAPPED     = 3'd6;
   localparam int QUIET_LIMIT = 5000;
   localparam int PHASES      = 12;
   localparam int PHASE_WORDS = 44;
   localparam int TAIL_CYCLES = 24;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_func = FUNC_NEVER;
   logic [WEIGHT_W-1:0] req_weight = '0;
   logic                req_zero_flag = 1'b0;
   logic                req_overload_flag = 1'b0;
   logic                req_negative_flag = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [CODE_W-1:0]   rsp_code;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [2:0]          csr_index = '0;
   logic [WEIGHT_W-1:0] csr_data = '0;

   code_tracker_type    book;
   int                  idle_pct = 0;
   int                  stall_pct = 0;
   int                  words_sent = 0;
   int                  reg_writes = 0;
   int                  quiet_cycles = 0;
   logic [WEIGHT_W-1:0] cur_full_scale = FULL_SCALE_RST;

   always #1 clock = ~clock;

   weight_to_analog_or_bcd_code DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_weight        (req_weight),
      .req_zero_flag     (req_zero_flag),
      .req_overload_flag (req_overload_flag),
      .req_negative_flag (req_negative_flag),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_code          (rsp_code),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // result side: sample the word first, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) book.check_code(rsp_code);
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // valid stays high across back-to-back words; dropped for idle cycles and by drain
   task automatic send_word(logic [1:0] func, logic [WEIGHT_W-1:0] weight,
                            logic zero, logic over, logic neg);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= func;
      req_weight        <= weight;
      req_zero_flag     <= zero;
      req_overload_flag <= over;
      req_negative_flag <= neg;
      do @(posedge clock); while (req_stall);
      book.note_word(func, weight, zero, over, neg);
      words_sent++;
   endtask

   task automatic send_random();
      logic [WEIGHT_W-1:0] w;
      case ($urandom_range(5))
         0: w = WEIGHT_W'($urandom);
         1: w = WEIGHT_W'($urandom_range(WEIGHT_MAX));
         2: w = WEIGHT_W'($urandom_range(999));
         3: w = WEIGHT_W'($urandom_range(2**WEIGHT_W - 1, WEIGHT_MAX - 9));
         4: w = (cur_full_scale > WEIGHT_W'(524287)) ? WEIGHT_W'($urandom)
                : WEIGHT_W'($urandom_range(2 * int'(cur_full_scale)));
         default: w = WEIGHT_W'($urandom_range(99) * 10000 + $urandom_range(9));
      endcase
      send_word(2'($urandom_range(3)), w, $urandom_range(3) == 0,
                $urandom_range(9) < 3, $urandom_range(1) == 1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
   endtask

   // csr_valid is left high between writes of one batch
   task automatic write_reg(logic [2:0] idx, logic [WEIGHT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      book.set_reg(idx, data);
      reg_writes++;
   endtask

   task automatic load_settings(logic [WEIGHT_W-1:0] fscale, logic bcd_on, logic sign_on,
                                logic invert_on, logic err_low, logic [1:0] first_digit,
                                logic [WEIGHT_W-1:0] junk);
      drain();
      write_reg(CSR_FULL_SCALE, fscale);
      write_reg(CSR_BCD_MODE, {junk[WEIGHT_W-1:1], bcd_on});
      write_reg(CSR_BCD_SIGNED, {junk[WEIGHT_W-1:1], sign_on});
      write_reg(CSR_INVERT_OUTPUT, {junk[WEIGHT_W-1:1], invert_on});
      write_reg(CSR_ERROR_LOW, {junk[WEIGHT_W-1:1], err_low});
      write_reg(CSR_DIGIT_START, {junk[WEIGHT_W-1:2], first_digit});
      if (junk != '0) write_reg(CSR_UNMAPPED, junk);
      csr_valid <= 1'b0;
      cur_full_scale = fscale;
   endtask

   initial begin
      logic [WEIGHT_W-1:0] fscale;
      logic [WEIGHT_W-1:0] junk;
      int                  mode;
      book = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: analog, full scale 999999
      send_word(FUNC_NEVER, '0, 1'b0, 1'b0, 1'b0);
      send_word(FUNC_NEVER, WEIGHT_MAX, 1'b0, 1'b0, 1'b1);
      send_word(FUNC_NEVER, '1, 1'b0, 1'b0, 1'b0);
      send_word(FUNC_NEVER, WEIGHT_W'(500000), 1'b1, 1'b0, 1'b0);
      send_word(FUNC_ON_OVERLOAD, WEIGHT_W'(123456), 1'b0, 1'b1, 1'b0);
      send_word(FUNC_ON_OVERLOAD, WEIGHT_W'(123456), 1'b0, 1'b0, 1'b0);
      send_word(FUNC_ALWAYS, '0, 1'b0, 1'b0, 1'b0);
      send_word(FUNC_SPARE, WEIGHT_W'(777), 1'b0, 1'b1, 1'b0);
      send_word(FUNC_SPARE, WEIGHT_W'(777), 1'b0, 1'b0, 1'b0);

      // tiny full scale saturates; inverted analog with low error code
      load_settings(WEIGHT_W'(1), 1'b0, 1'b0, 1'b1, 1'b1, 2'd1, '0);
      send_word(FUNC_NEVER, WEIGHT_MAX, 1'b0, 1'b0, 1'b0);
      send_word(FUNC_ALWAYS, WEIGHT_MAX, 1'b0, 1'b0, 1'b0);
      send_word(FUNC_NEVER, '0, 1'b1, 1'b0, 1'b0);

      // unsigned BCD, inverted: overload blocks inversion, func 2 does not
      load_settings(FULL_SCALE_RST, 1'b1, 1'b0, 1'b1, 1'b0, 2'd1, '0);
      send_word(FUNC_NEVER, WEIGHT_W'(123456), 1'b0, 1'b0, 1'b0);
      send_word(FUNC_ALWAYS, WEIGHT_W'(654321), 1'b0, 1'b0, 1'b0);
      send_word(FUNC_ON_OVERLOAD, WEIGHT_W'(654321), 1'b0, 1'b1, 1'b0);
      send_word(FUNC_NEVER, WEIGHT_MAX, 1'b0, 1'b1, 1'b0);

      // signed BCD: clamp, sign bit, inversion has no effect
      load_settings(FULL_SCALE_RST, 1'b1, 1'b1, 1'b1, 1'b1, 2'd3, '0);
      send_word(FUNC_NEVER, WEIGHT_MAX, 1'b0, 1'b0, 1'b0);
      send_word(FUNC_NEVER, WEIGHT_W'(123456), 1'b0, 1'b0, 1'b1);
      send_word(FUNC_ALWAYS, WEIGHT_W'(123456), 1'b0, 1'b0, 1'b1);

      // digit start zero acts as one, then digit start two
      load_settings(FULL_SCALE_RST, 1'b1, 1'b1, 1'b0, 1'b0, 2'd0, '0);
      send_word(FUNC_NEVER, WEIGHT_W'(123456), 1'b0, 1'b0, 1'b0);
      load_settings(FULL_SCALE_RST, 1'b1, 1'b1, 1'b0, 1'b0, 2'd2, '0);
      send_word(FUNC_NEVER, '1, 1'b0, 1'b0, 1'b1);

      for (int p = 0; p < PHASES; p++) begin
         case (p % 6)
            0: fscale = WEIGHT_W'(1);
            1: fscale = FULL_SCALE_RST;
            2: fscale = '0;
            3: fscale = '1;
            4: fscale = WEIGHT_W'($urandom_range(999, 1));
            default: fscale = WEIGHT_W'($urandom_range(WEIGHT_MAX, 1));
         endcase
         junk = (p >= 8) ? (WEIGHT_W'($urandom) & ~WEIGHT_W'(3)) : '0;
         load_settings(fscale, (p % 4) >= 2, $urandom_range(1) == 1, $urandom_range(1) == 1,
                       $urandom_range(1) == 1, 2'($urandom_range(3)), junk);
         mode = (p + p / 4) % 4;
         idle_pct  = (mode == 1) ? 64 : (mode == 3) ? 11 : 0;
         stall_pct = (mode == 2) ? 64 : (mode == 3) ? 11 : 0;
         for (int n = 0; n < PHASE_WORDS; n++) send_random();
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      book.finish_check();
      $display("Sent %0d words, checked %0d codes, %0d register writes",
               words_sent, book.checked, reg_writes);
      $display("Covered analog and BCD modes, signed and unsigned, all polarity and error settings");
      if (book.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* sim.f */
src/wtab_pkg.sv
src/weight_to_analog_or_bcd_code.sv
tb/sv/code_check_pkg.sv
tb/sv/testbench.sv
